### src/sitda_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and the binary-to-BCD step for the integer-to-text
// pipeline.
// ---------------------------------------------------------------------------
package sitda_pkg;

   localparam int ValueWidth   = 32;
   localparam int NumDigits    = 10;
   localparam int BcdWidth     = 4 * NumDigits;
   localparam int BitsPerStage = 8;
   localparam int NumStages    = ValueWidth / BitsPerStage;
   localparam int PosWidth     = $clog2(NumDigits);

   localparam logic [7:0] AsciiZero  = 8'd48;
   localparam logic [7:0] AsciiMinus = 8'd45;

   typedef logic [3:0] digit_type;

   // Payload carried down the conversion pipeline
   typedef struct packed {
      logic                  neg;
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
   } work_type;

   // One double-dabble step: correct each digit, then shift in one bit
   function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                       input logic               bit_in);
      logic [BcdWidth-1:0] adj;
      adj = bcd;
      for (int d = 0; d < NumDigits; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction

endpackage
`default_nettype wire

### src/signed_int_to_decimal_ascii.sv
`default_nettype none
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer carries a two's complement 32-bit value.
//   rsp_*  : one transfer per character, most significant first; a leading
//            '-' for negative values, leading zeros dropped (zero prints "0"),
//            rsp_tlast high on the final character of each number.
// Path: the first character of a number passes the sign stage (loaded by
//   its request transfer), then four 8-bit double-dabble stages, the
//   sequencer load and the output register.
// Throughput: one character per cycle while rsp_tready is high. A number
//   of 1 to 11 characters holds the output sequencer until its final
//   character is emitted, when it takes the next number; the pipeline ahead
//   of the sequencer holds up to five further numbers and accepts them back to back.
// Reset: synchronous, active high; empties every stage and the output
//   register. Data registers are not cleared.
// Stall: when rsp_tready is low the output register holds its character,
//   the sequencer waits and back-pressure ripples stage by stage to
//   req_tready; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value (signed)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic             rsp_tlast
);
   import sitda_pkg::*;

   // stage handshakes: index 0 is the sign stage, 1..NumStages the dabble
   logic     stg_valid [NumStages+1];
   logic     stg_ready [NumStages+1];
   work_type stg_work  [NumStages+1];

   // split sign and magnitude
   sitda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_work  (stg_work[0])
   );

   // convert magnitude to BCD, eight bits per stage
   for (genvar s = 0; s < NumStages; s++) begin : g_dabble
      sitda_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_work   (stg_work[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_work  (stg_work[s+1])
      );
   end

   // advance characters out, one per transfer
   sitda_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NumStages]),
      .in_ready  (stg_ready[NumStages]),
      .in_work   (stg_work[NumStages]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == AsciiMinus) ||
                     ((rsp_tdata >= AsciiZero) && (rsp_tdata <= AsciiZero + 8'd9)))
      else $error("character is neither a minus sign nor a digit");

   a_minus_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == AsciiMinus) |-> !rsp_tlast)
      else $error("minus sign marked as final character");

   a_minus_then_digit : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata == AsciiMinus) ##1 rsp_tvalid
         |-> rsp_tdata != AsciiMinus)
      else $error("two minus signs in a row");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
`default_nettype wire

### src/sitda_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitda_front
// Input stage: split the two's complement value into sign and magnitude.
// ---------------------------------------------------------------------------
module sitda_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [sitda_pkg::ValueWidth-1:0] in_value,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output sitda_pkg::work_type                  out_work
);
   import sitda_pkg::*;

   logic     valid_ff;
   work_type work_ff;
   work_type work_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      work_in.neg = in_value[ValueWidth-1];
      // the most negative value negates to itself, which is its magnitude
      work_in.bin = in_value[ValueWidth-1] ? (~in_value + ValueWidth'(1)) : in_value;
      work_in.bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule
`default_nettype wire

### src/sitda_dabble.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitda_dabble
// One conversion stage: shift eight magnitude bits into the BCD digits.
// ---------------------------------------------------------------------------
module sitda_dabble (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sitda_pkg::work_type in_work,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sitda_pkg::work_type     out_work
);
   import sitda_pkg::*;

   logic     valid_ff;
   work_type work_ff;
   work_type work_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      logic [BcdWidth-1:0] acc;
      acc = in_work.bcd;
      for (int j = 0; j < BitsPerStage; j++) begin
         acc = dabble_step(acc, in_work.bin[ValueWidth-1-j]);
      end
      work_in.neg = in_work.neg;
      work_in.bin = {in_work.bin[ValueWidth-BitsPerStage-1:0], {BitsPerStage{1'b0}}};
      work_in.bcd = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule
`default_nettype wire

### src/sitda_serial.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitda_serial
// Output sequencer: emit sign and significant digits one character a cycle while out_ready allows it.
// ---------------------------------------------------------------------------
module sitda_serial (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sitda_pkg::work_type in_work,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [7:0]              out_char,
   output logic                    out_last
);
   import sitda_pkg::*;

   logic                busy_ff, busy_in;
   logic                minus_ff, minus_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                tvalid_ff, tvalid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   digit_type           digits_ff [NumDigits];
   logic [PosWidth-1:0] top_pos;
   logic                emit_ok;
   logic                finishing;
   logic                load;

   assign out_valid = tvalid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   // index of the most significant non-zero digit, zero for the value zero
   always_comb begin
      top_pos = '0;
      for (int d = 0; d < NumDigits; d++) begin
         if (in_work.bcd[4*d +: 4] != 4'd0) begin
            top_pos = PosWidth'(d);
         end
      end
   end

   always_comb begin
      emit_ok   = !tvalid_ff || out_ready;
      finishing = busy_ff && emit_ok && !minus_ff && (pos_ff == '0);
      in_ready  = !busy_ff || finishing;
      load      = in_valid && in_ready;

      busy_in   = busy_ff;
      minus_in  = minus_ff;
      pos_in    = pos_ff;
      tvalid_in = tvalid_ff;
      char_in   = char_ff;
      last_in   = last_ff;

      if (emit_ok) begin
         tvalid_in = busy_ff;
         if (busy_ff) begin
            if (minus_ff) begin
               char_in  = AsciiMinus;
               last_in  = 1'b0;
               minus_in = 1'b0;
            end else begin
               char_in = AsciiZero + {4'd0, digits_ff[pos_ff]};
               last_in = (pos_ff == '0);
               if (pos_ff == '0) begin
                  busy_in = 1'b0;
               end else begin
                  pos_in = pos_ff - PosWidth'(1);
               end
            end
         end
      end

      if (load) begin
         busy_in  = 1'b1;
         minus_in = in_work.neg;
         pos_in   = top_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         minus_ff  <= 1'b0;
         pos_ff    <= '0;
         tvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         minus_ff  <= minus_in;
         pos_ff    <= pos_in;
         tvalid_ff <= tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (load) begin
         for (int d = 0; d < NumDigits; d++) begin
            digits_ff[d] <= in_work.bcd[4*d +: 4];
         end
      end
   end

endmodule
`default_nettype wire
